FILE: rtl/cvse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cvse_pkg;

    localparam int DEV_W      = 4;
    localparam int PCT_W      = 8;
    localparam int MV_W       = 16;
    localparam int CFG_IDX_W  = 2;

    // signed accumulator and dividend magnitude widths for the estimate datapath
    localparam int ACC_W      = 42;
    localparam int MAG_W      = ACC_W - 1;

    // compare width that covers every legal device count and first adjusted index
    localparam int IDX_CMP_W  = 7;

    localparam int DEVICE_COUNT_DEF          = 16;
    localparam int FIRST_ADJUSTED_DEVICE_DEF = 8;

    localparam logic [PCT_W-1:0] PCT_FULL   = 8'd100;
    localparam logic [PCT_W-1:0] PCT_ALMOST = 8'd99;
    localparam logic [PCT_W-1:0] PCT_EMPTY  = 8'd0;

    localparam logic [CFG_IDX_W-1:0] REG_FULL_CELL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CELL = 2'd1;

    typedef struct packed {
        logic start;
        logic clear;
    } mul_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/cvse_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cvse_in_if
    import cvse_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [DEV_W-1:0] device_index;
    logic [PCT_W-1:0] reported_percent;
    logic [MV_W-1:0]  max_cell_mv;
    logic [MV_W-1:0]  min_cell_mv;

    modport source (
        output valid, device_index, reported_percent, max_cell_mv, min_cell_mv,
        input  ready
    );
    modport sink (
        input  valid, device_index, reported_percent, max_cell_mv, min_cell_mv,
        output ready
    );
endinterface

interface cvse_out_if
    import cvse_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PCT_W-1:0] soc_percent;

    modport source (
        output valid, soc_percent,
        input  ready
    );
    modport sink (
        input  valid, soc_percent,
        output ready
    );
endinterface

interface cvse_cfg_if
    import cvse_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [MV_W-1:0]      data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/cell_voltage_soc_estimator.sv
// Path: an item that needs no linear estimate goes from S_IDLE straight to S_FIN; the
// linear estimate also runs through two 41-step bit-serial divisions and three
// shift-add multiplies (16, 16 and 7 steps at most); any stall on the result holds S_FIN.
// Throughput: one item in flight; the next item is taken in the cycle after the result
// lands in the output register. Reset clears the thresholds, all full latches, the
// sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module cell_voltage_soc_estimator
    import cvse_pkg::*;
#(
    parameter int DEVICE_COUNT          = DEVICE_COUNT_DEF,
    parameter int FIRST_ADJUSTED_DEVICE = FIRST_ADJUSTED_DEVICE_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    cvse_in_if.sink   sample,
    cvse_out_if.source result,
    cvse_cfg_if.sink  cfg
);

    localparam int LIW = $clog2(DEVICE_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_DIV1,
        S_SUB,
        S_MUL3,
        S_DIV2,
        S_FIN
    } state_t;

    state_t                  state_reg, state_next;
    logic [MV_W-1:0]         full_reg,  full_next;
    logic [MV_W-1:0]         empty_reg, empty_next;
    logic [DEVICE_COUNT-1:0] latch_reg, latch_next;
    logic [MV_W-1:0]         hi_reg,    hi_next;
    logic [MV_W-1:0]         lo_reg,    lo_next;
    logic [MV_W-1:0]         dmag_reg,  dmag_next;
    logic                    dneg_reg,  dneg_next;
    logic                    neg_reg,   neg_next;
    logic signed [ACC_W-1:0] v_reg,     v_next;
    logic [PCT_W-1:0]        res_reg,   res_next;
    logic [PCT_W-1:0]        soc_reg,   soc_next;
    logic                    ovld_reg,  ovld_next;

    mul_cmd_t                mul_cmd;
    logic signed [ACC_W-1:0] mul_a;
    logic [MV_W-1:0]         mul_b;
    logic                    mul_busy;
    logic signed [ACC_W-1:0] mul_acc;
    logic                    div_start;
    logic [MAG_W-1:0]        div_dividend;
    logic                    div_busy;
    logic [MAG_W-1:0]        div_q;

    logic                    accept;
    logic [IDX_CMP_W-1:0]    dev_cmp;
    logic [LIW-1:0]          dev_idx;
    logic                    adjusted;
    logic                    latch_kept;
    logic                    acc_neg;
    logic signed [ACC_W-1:0] acc_abs;
    logic signed [ACC_W-1:0] q_s;
    logic signed [MV_W:0]    d_s;
    logic                    r_neg;
    logic                    r_over;

    cvse_smul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mul_cmd),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .acc   (mul_acc)
    );

    cvse_sdiv u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dmag_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign sample.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign result.valid       = ovld_reg;
    assign result.soc_percent = soc_reg;

    assign accept   = sample.valid && sample.ready;
    assign dev_cmp  = IDX_CMP_W'(sample.device_index);
    assign dev_idx  = dev_cmp[LIW-1:0];
    assign adjusted = (dev_cmp >= IDX_CMP_W'(FIRST_ADJUSTED_DEVICE))
                   && (dev_cmp <  IDX_CMP_W'(DEVICE_COUNT));
    assign latch_kept = latch_reg[dev_idx] && (sample.reported_percent >= PCT_FULL);

    assign acc_neg = mul_acc[ACC_W-1];
    assign acc_abs = acc_neg ? -mul_acc : mul_acc;
    assign q_s     = $signed({1'b0, div_q});
    assign d_s     = $signed({1'b0, full_reg}) - $signed({1'b0, empty_reg});
    assign r_neg   = neg_reg && (div_q != '0);
    assign r_over  = !neg_reg && (div_q > MAG_W'(PCT_FULL));

    always_comb
    begin
        state_next   = state_reg;
        full_next    = full_reg;
        empty_next   = empty_reg;
        latch_next   = latch_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        dmag_next    = dmag_reg;
        dneg_next    = dneg_reg;
        neg_next     = neg_reg;
        v_next       = v_reg;
        res_next     = res_reg;
        soc_next     = soc_reg;
        ovld_next    = ovld_reg;
        mul_cmd      = '0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = acc_abs[MAG_W-1:0];

        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FULL_CELL:  full_next  = cfg.data;
                REG_EMPTY_CELL: empty_next = cfg.data;
                default: ;
            endcase
        end

        if (ovld_reg && result.ready)
        begin
            ovld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    hi_next    = sample.max_cell_mv;
                    lo_next    = sample.min_cell_mv;
                    dmag_next  = d_s[MV_W] ? MV_W'(-d_s) : d_s[MV_W-1:0];
                    dneg_next  = d_s[MV_W];
                    state_next = S_FIN;
                    if (!adjusted)
                    begin
                        res_next = sample.reported_percent;
                    end
                    else if ((full_reg != '0)
                             && ((sample.max_cell_mv >= full_reg) || latch_kept))
                    begin
                        latch_next[dev_idx] = 1'b1;
                        res_next            = PCT_FULL;
                    end
                    else
                    begin
                        latch_next[dev_idx] = latch_kept;
                        if ((full_reg != '0) && (empty_reg != '0))
                        begin
                            if (full_reg == empty_reg)
                            begin
                                res_next = PCT_EMPTY;
                            end
                            else
                            begin
                                mul_cmd.start = 1'b1;
                                mul_cmd.clear = 1'b1;
                                mul_a = ACC_W'($signed({1'b0, sample.max_cell_mv})
                                             - $signed({1'b0, empty_reg}));
                                mul_b = sample.max_cell_mv;
                                state_next = S_MUL1;
                            end
                        end
                        else if (sample.reported_percent == PCT_FULL)
                        begin
                            res_next = PCT_ALMOST;
                        end
                        else
                        begin
                            res_next = sample.reported_percent;
                        end
                    end
                end
            end
            S_MUL1:
            begin
                if (!mul_busy)
                begin
                    mul_cmd.start = 1'b1;
                    mul_a = ACC_W'($signed({1'b0, full_reg}) - $signed({1'b0, hi_reg}));
                    mul_b = lo_reg;
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                if (!mul_busy)
                begin
                    div_start  = 1'b1;
                    neg_next   = acc_neg ^ dneg_reg;
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (!div_busy)
                begin
                    v_next     = neg_reg ? -q_s : q_s;
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                mul_cmd.start = 1'b1;
                mul_cmd.clear = 1'b1;
                mul_a = v_reg - $signed({{(ACC_W-MV_W){1'b0}}, empty_reg});
                mul_b = MV_W'(PCT_FULL);
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                if (!mul_busy)
                begin
                    div_start  = 1'b1;
                    neg_next   = acc_neg ^ dneg_reg;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (!div_busy)
                begin
                    if (r_neg || (lo_reg <= empty_reg))
                    begin
                        res_next = PCT_EMPTY;
                    end
                    else if (r_over || (hi_reg >= full_reg))
                    begin
                        res_next = PCT_FULL;
                    end
                    else
                    begin
                        res_next = PCT_W'(div_q);
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!ovld_reg || result.ready)
                begin
                    ovld_next  = 1'b1;
                    soc_next   = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            full_reg  <= '0;
            empty_reg <= '0;
            latch_reg <= '0;
            hi_reg    <= '0;
            lo_reg    <= '0;
            dmag_reg  <= '0;
            dneg_reg  <= 1'b0;
            neg_reg   <= 1'b0;
            v_reg     <= '0;
            res_reg   <= '0;
            soc_reg   <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            full_reg  <= full_next;
            empty_reg <= empty_next;
            latch_reg <= latch_next;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
            dmag_reg  <= dmag_next;
            dneg_reg  <= dneg_next;
            neg_reg   <= neg_next;
            v_reg     <= v_next;
            res_reg   <= res_next;
            soc_reg   <= soc_next;
            ovld_reg  <= ovld_next;
        end
    end

    a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!mul_busy && !div_busy))
        else $error("arithmetic unit busy while idle");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (dmag_reg != '0))
        else $error("division started with zero divisor");

    a_dividend_fits: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !acc_abs[ACC_W-1])
        else $error("dividend magnitude overflows");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (!ovld_reg ##1 ovld_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result loaded outside final state");

endmodule

`default_nettype wire

FILE: rtl/cvse_smul.sv
`timescale 1ns / 1ps
`default_nettype none

// shift-add multiply-accumulate, one multiplier bit per cycle, LSB first
module cvse_smul
    import cvse_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire mul_cmd_t                cmd,
    input  wire logic signed [ACC_W-1:0] a,
    input  wire logic [MV_W-1:0]         b,
    output logic                         busy,
    output logic signed [ACC_W-1:0]      acc
);

    logic signed [ACC_W-1:0] acc_reg,  acc_next;
    logic signed [ACC_W-1:0] a_sh_reg, a_sh_next;
    logic [MV_W-1:0]         b_sh_reg, b_sh_next;

    always_comb
    begin
        acc_next  = acc_reg;
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        if (cmd.start)
        begin
            a_sh_next = a;
            b_sh_next = b;
            if (cmd.clear)
            begin
                acc_next = '0;
            end
        end
        else if (b_sh_reg != '0)
        begin
            if (b_sh_reg[0])
            begin
                acc_next = acc_reg + a_sh_reg;
            end
            a_sh_next = a_sh_reg <<< 1;
            b_sh_next = b_sh_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            a_sh_reg <= '0;
            b_sh_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            a_sh_reg <= a_sh_next;
            b_sh_reg <= b_sh_next;
        end
    end

    assign busy = (b_sh_reg != '0);
    assign acc  = acc_reg;

endmodule

`default_nettype wire

FILE: rtl/cvse_sdiv.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring unsigned divider, one quotient bit per cycle
module cvse_sdiv
    import cvse_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [MAG_W-1:0] dividend,
    input  wire logic [MV_W-1:0]  divisor,
    output logic                  busy,
    output logic [MAG_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [MAG_W-1:0] q_reg,   q_next;
    logic [MV_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MV_W:0]    trial;
    logic [MV_W:0]    diff;
    logic             ge;

    assign trial = {rem_reg, q_reg[MAG_W-1]};
    assign ge    = (trial >= {1'b0, divisor});
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        q_next   = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            q_next   = dividend;
            rem_next = '0;
            cnt_next = CNT_W'(MAG_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? diff[MV_W-1:0] : trial[MV_W-1:0];
            q_next   = {q_reg[MAG_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg   <= '0;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg;

endmodule

`default_nettype wire

FILE: tb/sv/cvse_soc_checker.sv
`timescale 1ns / 1ps

module cvse_soc_checker
    import cvse_pkg::*;
#(
    parameter int DEVICE_COUNT          = DEVICE_COUNT_DEF,
    parameter int FIRST_ADJUSTED_DEVICE = FIRST_ADJUSTED_DEVICE_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    cvse_in_if   sample,
    cvse_out_if  result,
    cvse_cfg_if  cfg,
    output int   mismatch_count,
    output int   pending_count
);

    logic [MV_W-1:0]         full_mv;
    logic [MV_W-1:0]         empty_mv;
    logic [DEVICE_COUNT-1:0] full_latch;
    logic [PCT_W-1:0]        soc_expected[$];
    int                      errors = 0;
    int                      outstanding = 0;

    assign mismatch_count = errors;
    assign pending_count  = outstanding;

    function automatic logic [PCT_W-1:0] linear_soc(input logic [MV_W-1:0] hi,
                                                    input logic [MV_W-1:0] lo);
        longint hi_l;
        longint lo_l;
        longint full_l;
        longint empty_l;
        longint span;
        longint v;
        longint r;
        hi_l    = longint'(hi);
        lo_l    = longint'(lo);
        full_l  = longint'(full_mv);
        empty_l = longint'(empty_mv);
        span    = full_l - empty_l;
        if (span == 0)
            return PCT_EMPTY;
        v = ((hi_l - empty_l) * hi_l + (full_l - hi_l) * lo_l) / span;
        r = ((v - empty_l) * 100) / span;
        if (r < 0 || lo <= empty_mv)
            return PCT_EMPTY;
        if (r > 100 || hi >= full_mv)
            return PCT_FULL;
        return r[PCT_W-1:0];
    endfunction

    // updates the per-device full latch as a side effect
    function automatic logic [PCT_W-1:0] adjust_soc(input logic [DEV_W-1:0] dev,
                                                    input logic [PCT_W-1:0] pct,
                                                    input logic [MV_W-1:0]  hi,
                                                    input logic [MV_W-1:0]  lo);
        int d;
        d = int'(dev);
        if (d < FIRST_ADJUSTED_DEVICE || d >= DEVICE_COUNT)
            return pct;
        if (pct < PCT_FULL)
            full_latch[d] = 1'b0;
        if (full_mv != 0 && (hi >= full_mv || full_latch[d]))
        begin
            full_latch[d] = 1'b1;
            return PCT_FULL;
        end
        if (full_mv != 0 && empty_mv != 0)
            return linear_soc(hi, lo);
        if (pct == PCT_FULL)
            return PCT_ALMOST;
        return pct;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [PCT_W-1:0] want;
        if (!rst_n)
        begin
            full_mv    = '0;
            empty_mv   = '0;
            full_latch = '0;
            soc_expected.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_FULL_CELL:  full_mv  = cfg.data;
                    REG_EMPTY_CELL: empty_mv = cfg.data;
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (soc_expected.size() == 0)
                begin
                    errors++;
                    $display("%0t: soc_percent expected none actual %0d",
                             $time, result.soc_percent);
                end
                else
                begin
                    want = soc_expected.pop_front();
                    if (result.soc_percent !== want)
                    begin
                        errors++;
                        $display("%0t: soc_percent expected %0d actual %0d",
                                 $time, want, result.soc_percent);
                    end
                end
            end
            if (sample.valid && sample.ready)
                soc_expected.push_back(adjust_soc(sample.device_index,
                                                  sample.reported_percent,
                                                  sample.max_cell_mv,
                                                  sample.min_cell_mv));
            outstanding <= soc_expected.size();
        end
    end

endmodule

FILE: tb/sv/tb_cell_voltage_soc_estimator.sv
`timescale 1ns / 1ps

module tb_cell_voltage_soc_estimator;
    import cvse_pkg::*;

    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 123;
    localparam int LIMIT_CYCLES    = 1_000_000;
    localparam int SETTLE_CYCLES   = 150;

    // thresholds and idling per random phase
    localparam int FULL_TAB[PHASES]  = '{4200, 0, 65535, 4200, 3700, 1, 65535, 3000, 12000, 4100};
    localparam int EMPTY_TAB[PHASES] = '{3000, 3000, 65535, 0, 3700, 65535, 1, 3300, 2500, 3200};
    localparam int SRC_IDLE[PHASES]  = '{0, 60, 0, 20, 0, 60, 0, 20, 60, 0};
    localparam int SINK_STALL[PHASES] = '{0, 0, 60, 20, 0, 0, 60, 20, 60, 0};

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    int              cycle_count = 0;
    int              src_idle_pct = 0;
    int              sink_stall_pct = 0;
    int              mismatch_count;
    int              pending_count;
    logic [MV_W-1:0] cur_full = '0;
    logic [MV_W-1:0] cur_empty = '0;

    cvse_in_if  sample();
    cvse_out_if result();
    cvse_cfg_if cfg();

    cell_voltage_soc_estimator uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .result (result),
        .cfg    (cfg)
    );

    cvse_soc_checker soc_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         (sample),
        .result         (result),
        .cfg            (cfg),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[cell_voltage_soc_estimator] ERROR");
            $finish;
        end
    end

    always @(negedge clk)
        result.ready = ($urandom_range(0, 99) >= sink_stall_pct);

    task automatic send_sample(input logic [DEV_W-1:0] dev, input logic [PCT_W-1:0] pct,
                               input logic [MV_W-1:0] hi, input logic [MV_W-1:0] lo);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            @(negedge clk);
            sample.valid = 1'b0;
        end
        @(negedge clk);
        sample.valid            = 1'b1;
        sample.device_index     = dev;
        sample.reported_percent = pct;
        sample.max_cell_mv      = hi;
        sample.min_cell_mv      = lo;
        do
            @(posedge clk);
        while (!sample.ready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        sample.valid = 1'b0;
        while (pending_count != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] value);
        @(negedge clk);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = value;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 1'b0;
        if (idx == REG_FULL_CELL)
            cur_full = value;
        else
            cur_empty = value;
    endtask

    task automatic set_thresholds(input int full, input int empty);
        wait_drained();
        write_reg(REG_FULL_CELL, MV_W'(full));
        write_reg(REG_EMPTY_CELL, MV_W'(empty));
    endtask

    function automatic logic [MV_W-1:0] pick_mv(input int center);
        int v;
        if ($urandom_range(0, 3) == 0)
            return MV_W'($urandom_range(0, 65535));
        v = center + int'($urandom_range(0, 800)) - 400;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return MV_W'(v);
    endfunction

    task automatic send_random();
        logic [DEV_W-1:0] dev;
        logic [PCT_W-1:0] pct;
        if ($urandom_range(0, 3) == 0)
            dev = DEV_W'($urandom_range(0, 15));
        else
            dev = DEV_W'($urandom_range(8, 15));
        case ($urandom_range(0, 3))
            0:       pct = PCT_W'($urandom_range(0, 255));
            1:       pct = PCT_FULL;
            2:       pct = PCT_W'($urandom_range(90, 110));
            default: pct = PCT_W'($urandom_range(0, 100));
        endcase
        send_sample(dev, pct, pick_mv(cur_full != 0 ? int'(cur_full) : 4200),
                    pick_mv(cur_empty != 0 ? int'(cur_empty) : 3000));
    endtask

    initial
    begin
        sample.valid            = 1'b0;
        sample.device_index     = '0;
        sample.reported_percent = '0;
        sample.max_cell_mv      = '0;
        sample.min_cell_mv      = '0;
        cfg.valid               = 1'b0;
        cfg.index               = '0;
        cfg.data                = '0;
        result.ready            = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // thresholds at reset: disabled
        send_sample(4'd8, 8'd100, 16'd4000, 16'd3500);
        send_sample(4'd15, 8'd255, 16'd65535, 16'd0);
        send_sample(4'd0, 8'd100, 16'd65535, 16'd65535);
        send_sample(4'd7, 8'd0, 16'd0, 16'd0);
        send_sample(4'd9, 8'd0, 16'd0, 16'd65535);

        set_thresholds(4200, 3000);
        send_sample(4'd8, 8'd100, 16'd4200, 16'd3100);
        send_sample(4'd8, 8'd101, 16'd3500, 16'd3400);
        send_sample(4'd8, 8'd99, 16'd3500, 16'd3400);
        send_sample(4'd9, 8'd50, 16'd4100, 16'd3000);
        send_sample(4'd10, 8'd50, 16'd4199, 16'd4199);
        send_sample(4'd11, 8'd50, 16'd0, 16'd0);
        send_sample(4'd12, 8'd50, 16'd65535, 16'd65535);
        send_sample(4'd12, 8'd0, 16'd3600, 16'd3200);
        send_sample(4'd3, 8'd150, 16'd4200, 16'd3000);

        // equal thresholds
        set_thresholds(4200, 4200);
        send_sample(4'd13, 8'd50, 16'd4100, 16'd4150);
        send_sample(4'd13, 8'd255, 16'd4300, 16'd0);

        set_thresholds(3000, 0);
        send_sample(4'd14, 8'd100, 16'd2000, 16'd1000);
        send_sample(4'd14, 8'd100, 16'd3000, 16'd1000);

        set_thresholds(0, 3000);
        send_sample(4'd15, 8'd100, 16'd4000, 16'd3500);
        send_sample(4'd15, 8'd42, 16'd4000, 16'd3500);

        for (int p = 0; p < PHASES; p++)
        begin
            set_thresholds(FULL_TAB[p], EMPTY_TAB[p]);
            src_idle_pct   = SRC_IDLE[p];
            sink_stall_pct = SINK_STALL[p];
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (i == ITEMS_PER_PHASE / 2)
                    wait_drained();
                send_random();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("[cell_voltage_soc_estimator] OK");
        else
            $display("[cell_voltage_soc_estimator] ERROR");
        $finish;
    end

endmodule
